FILE: sv/lz4d_pkg.sv
// Shared types and constants for the LZ4 block decompressor.
// Used by every module of the block but lz4d_ram; has no dependencies.
package lz4d_pkg;

    localparam int HIST_DEPTH = 65536;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int LEN_W      = 31;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [LEN_W-1:0] OUT_SIZE_RESET = 31'd65536;
    localparam logic [LEN_W-1:0] RUN_MAX        = 31'h7FFF_FFFF;
    localparam logic [LEN_W-1:0] MIN_MATCH      = 31'd4;
    localparam logic [3:0]       NIB_MASK       = 4'hF;
    localparam logic [7:0]       EXT_BYTE       = 8'd255;

    // Register index, taken from paddr[2].
    localparam logic REG_OUTPUT_SIZE = 1'b0;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_OFFSET = 2'd1;
    localparam logic [1:0] ST_OVERRUN    = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_START = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_TOKEN  = 3'd0,
        PH_LITEXT = 3'd1,
        PH_LIT    = 3'd2,
        PH_OFFLO  = 3'd3,
        PH_OFFHI  = 3'd4,
        PH_MATEXT = 3'd5,
        PH_COPY   = 3'd6,
        PH_HALT   = 3'd7
    } t_phase;

    // One decoded beat handed from the parser to the output pipeline.
    typedef struct packed {
        logic               from_ram;
        logic [7:0]         lit_byte;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [HIST_AW-1:0] rd_addr;
        logic               out_valid;
        logic               accepted;
        logic               copy_pending;
        logic               block_done;
        logic [1:0]         status;
    } t_issue;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [7:0]         data;
    } t_ram_wr;

endpackage

FILE: sv/lz4_block_decompressor.sv
// LZ4 block decompressor, one compressed or decompressed byte per beat.
// Input beats carry an opcode: push a compressed byte, pull one pending match
// byte, or start a new block. Every input beat yields exactly one result beat
// with the output byte, its valid flag and the parser status after the beat.
// A result beat is registered first in the read stage, which reads the 64 KiB
// history RAM, and then in the output register. With no stall on the output,
// one beat is accepted and one delivered in every cycle; the single read port
// of the history RAM sets that figure, and a match with an offset of one byte
// is served by forwarding from the write port.
// When the receiver stalls, the output register holds its beat and the read
// stage takes one more; o_stall is high in every cycle in which both hold a
// beat and i_stall is high.
// Reset clears the parser and the pipeline and sets output_size to 65536.
// The history RAM is not cleared; offsets are checked against the bytes
// written in the current block, so unwritten entries never reach the output.
// The APB register output_size lies at address 0 and takes effect at once.
// Depends on lz4d_pkg, lz4d_ctrl, lz4d_pipe and lz4d_ram.
module lz4_block_decompressor
    import lz4d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_in_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_out_valid,
    output logic              o_accepted,
    output logic              o_copy_pending,
    output logic              o_block_done,
    output logic [1:0]        o_status
);

    t_issue     issue;
    t_ram_wr    ram_wr;
    logic [7:0] ram_q;
    logic       can_take;
    logic       accept;

    assign pready  = 1'b1;
    assign o_stall = !can_take;
    assign accept  = i_valid && can_take;

    lz4d_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .i_accept  (accept),
        .i_opcode  (i_opcode),
        .i_in_byte (i_in_byte),
        .o_issue   (issue)
    );

    lz4d_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_wr.en),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (accept),
        .i_raddr (issue.rd_addr),
        .o_rdata (ram_q)
    );

    lz4d_pipe u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_issue        (issue),
        .i_ram_q        (ram_q),
        .o_ram_wr       (ram_wr),
        .o_can_take     (can_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_out_valid    (o_out_valid),
        .o_accepted     (o_accepted),
        .o_copy_pending (o_copy_pending),
        .o_block_done   (o_block_done),
        .o_status       (o_status)
    );

endmodule

FILE: sv/lz4d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-first: a read of the address being written returns the old contents.
module lz4d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lz4d_ctrl.sv
// Configuration register and LZ4 sequence parser of the decompressor.
// Depends on lz4d_pkg; emits one t_issue per accepted beat.
module lz4d_ctrl
    import lz4d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    input  logic              i_accept,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_in_byte,
    output t_issue            o_issue
);

    t_phase             r_phase, n_phase;
    logic [3:0]         r_nib, n_nib;
    logic [LEN_W-1:0]   r_run, n_run;
    logic [HIST_AW-1:0] r_dist, n_dist;
    logic [LEN_W-1:0]   r_bw, n_bw;
    logic [1:0]         r_status, n_status;
    logic [LEN_W-1:0]   r_osize;

    logic [LEN_W:0]     ext_sum;
    logic [LEN_W-1:0]   ext_sat;
    logic [LEN_W-1:0]   bw_inc;
    logic [LEN_W-1:0]   run_dec;
    logic [HIST_AW-1:0] dist_full;
    logic               bw_full;
    logic               dist_bad;
    logic               err_set;
    logic [1:0]         err_code;
    t_issue             iss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osize <= OUT_SIZE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_OUTPUT_SIZE) begin
            r_osize <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_OUTPUT_SIZE) ? {1'b0, r_osize} : '0;

    // Extension bytes; the final match extension byte also adds the minimum match.
    assign ext_sum = {1'b0, r_run} + {{(LEN_W-7){1'b0}}, i_in_byte}
                   + ((r_phase == PH_MATEXT && i_in_byte != EXT_BYTE)
                      ? {1'b0, MIN_MATCH} : '0);
    assign ext_sat   = ext_sum[LEN_W] ? RUN_MAX : ext_sum[LEN_W-1:0];
    assign bw_inc    = r_bw + 1'b1;
    assign run_dec   = r_run - 1'b1;
    assign bw_full   = (r_bw >= r_osize);
    assign dist_full = {i_in_byte, r_dist[7:0]};
    assign dist_bad  = (dist_full == '0) ||
                       ({{(LEN_W-HIST_AW){1'b0}}, dist_full} > r_bw);

    always_comb begin
        n_phase  = r_phase;
        n_nib    = r_nib;
        n_run    = r_run;
        n_dist   = r_dist;
        n_bw     = r_bw;
        n_status = r_status;
        err_set  = 1'b0;
        err_code = ST_OK;
        iss              = '0;
        iss.accepted     = 1'b1;
        iss.wr_addr      = r_bw[HIST_AW-1:0];
        iss.rd_addr      = r_bw[HIST_AW-1:0] - r_dist;

        unique case (t_opcode'(i_opcode))
            OP_PUSH: begin
                if (r_phase == PH_COPY) begin
                    iss.accepted = 1'b0;
                end else begin
                    unique case (r_phase)
                        PH_TOKEN: begin
                            n_nib = i_in_byte[3:0];
                            n_run = {{(LEN_W-4){1'b0}}, i_in_byte[7:4]};
                            if (i_in_byte[7:4] == NIB_MASK) begin
                                n_phase = PH_LITEXT;
                            end else if (i_in_byte[7:4] != 4'd0) begin
                                n_phase = PH_LIT;
                            end else begin
                                n_phase = bw_full ? PH_HALT : PH_OFFLO;
                            end
                        end
                        PH_LITEXT: begin
                            n_run = ext_sat;
                            if (i_in_byte != EXT_BYTE) begin
                                if (ext_sat != '0) begin
                                    n_phase = PH_LIT;
                                end else begin
                                    n_phase = bw_full ? PH_HALT : PH_OFFLO;
                                end
                            end
                        end
                        PH_LIT: begin
                            if (bw_full) begin
                                err_set  = 1'b1;
                                err_code = ST_OVERRUN;
                            end else begin
                                iss.wr_en     = 1'b1;
                                iss.out_valid = 1'b1;
                                iss.lit_byte  = i_in_byte;
                                n_bw          = bw_inc;
                                n_run         = run_dec;
                                if (run_dec == '0) begin
                                    n_phase = (bw_inc >= r_osize) ? PH_HALT : PH_OFFLO;
                                end
                            end
                        end
                        PH_OFFLO: begin
                            n_dist  = {{(HIST_AW-8){1'b0}}, i_in_byte};
                            n_phase = PH_OFFHI;
                        end
                        PH_OFFHI: begin
                            n_dist = dist_full;
                            if (dist_bad) begin
                                err_set  = 1'b1;
                                err_code = ST_BAD_OFFSET;
                            end else if (r_nib == NIB_MASK) begin
                                n_run   = {{(LEN_W-4){1'b0}}, NIB_MASK};
                                n_phase = PH_MATEXT;
                            end else begin
                                n_run   = {{(LEN_W-4){1'b0}}, r_nib} + MIN_MATCH;
                                n_phase = PH_COPY;
                            end
                        end
                        PH_MATEXT: begin
                            n_run = ext_sat;
                            if (i_in_byte != EXT_BYTE) begin
                                n_phase = PH_COPY;
                            end
                        end
                        PH_COPY: begin
                            n_phase = r_phase;
                        end
                        PH_HALT: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            OP_PULL: begin
                if (r_phase == PH_COPY) begin
                    if (bw_full) begin
                        err_set  = 1'b1;
                        err_code = ST_OVERRUN;
                    end else begin
                        iss.from_ram  = 1'b1;
                        iss.wr_en     = 1'b1;
                        iss.out_valid = 1'b1;
                        n_bw          = bw_inc;
                        n_run         = run_dec;
                        if (run_dec == '0) begin
                            n_phase = PH_TOKEN;
                        end
                    end
                end
            end
            OP_START: begin
                n_phase  = PH_TOKEN;
                n_nib    = '0;
                n_run    = '0;
                n_dist   = '0;
                n_bw     = '0;
                n_status = ST_OK;
            end
            OP_NOP: begin
                n_phase = r_phase;
            end
        endcase

        if (err_set) begin
            n_phase = PH_HALT;
            if (r_status == ST_OK) begin
                n_status = err_code;
            end
        end

        iss.copy_pending = (n_phase == PH_COPY);
        iss.block_done   = (n_bw >= r_osize);
        iss.status       = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOKEN;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nib    <= '0;
            r_run    <= '0;
            r_dist   <= '0;
            r_bw     <= '0;
            r_status <= ST_OK;
        end else if (i_accept) begin
            r_nib    <= n_nib;
            r_run    <= n_run;
            r_dist   <= n_dist;
            r_bw     <= n_bw;
            r_status <= n_status;
        end
    end

    assign o_issue = iss;

endmodule

FILE: sv/lz4d_pipe.sv
// History read stage, write-back with forwarding, and output register.
// Depends on lz4d_pkg; drives the write port of the history RAM.
module lz4d_pipe
    import lz4d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_issue     i_issue,
    input  logic [7:0] i_ram_q,
    output t_ram_wr    o_ram_wr,
    output logic       o_can_take,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_accepted,
    output logic       o_copy_pending,
    output logic       o_block_done,
    output logic [1:0] o_status
);

    t_issue     r_b;
    logic       r_b_valid;
    logic       r_fwd_hit;
    logic [7:0] r_fwd_data;
    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_out_valid;
    logic       r_o_accepted;
    logic       r_o_copy_pending;
    logic       r_o_block_done;
    logic [1:0] r_o_status;

    logic       b_move;
    logic [7:0] b_byte;

    assign b_move     = r_b_valid && (!r_o_valid || !i_stall);
    assign o_can_take = !r_b_valid || b_move;

    // The RAM is read-first, so a byte written in the cycle of the read
    // is taken from the write port instead.
    assign b_byte = r_b.from_ram ? (r_fwd_hit ? r_fwd_data : i_ram_q) : r_b.lit_byte;

    assign o_ram_wr.en   = b_move && r_b.wr_en;
    assign o_ram_wr.addr = r_b.wr_addr;
    assign o_ram_wr.data = b_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b        <= i_issue;
            r_fwd_hit  <= o_ram_wr.en && (r_b.wr_addr == i_issue.rd_addr);
            r_fwd_data <= b_byte;
        end
        if (b_move) begin
            r_o_byte         <= b_byte;
            r_o_out_valid    <= r_b.out_valid;
            r_o_accepted     <= r_b.accepted;
            r_o_copy_pending <= r_b.copy_pending;
            r_o_block_done   <= r_b.block_done;
            r_o_status       <= r_b.status;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_out_valid    = r_o_out_valid;
    assign o_accepted     = r_o_accepted;
    assign o_copy_pending = r_o_copy_pending;
    assign o_block_done   = r_o_block_done;
    assign o_status       = r_o_status;

endmodule

FILE: sv/lz4d_checker.sv
// Port-level assertions for the LZ4 block decompressor and their bind.
// Depends on lz4d_pkg and on lz4_block_decompressor being elaborated.
module lz4d_checker
    import lz4d_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid,
    input logic       o_accepted,
    input logic       o_copy_pending,
    input logic [1:0] o_status
);

    // A result beat held by the receiver keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_out_valid))
        else $error("stalled result beat changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    // A produced byte never comes from a rejected push.
    a_emit_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_accepted)
        else $error("byte produced by a rejected beat");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_out_byte == 8'd0)
        else $error("nonzero byte without out_valid");

    // A push is only rejected while a copy is pending, and it leaves the copy pending.
    a_reject_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_copy_pending && o_status == ST_OK)
        else $error("push rejected outside a pending copy");

endmodule

bind lz4_block_decompressor lz4d_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_byte     (o_out_byte),
    .o_out_valid    (o_out_valid),
    .o_accepted     (o_accepted),
    .o_copy_pending (o_copy_pending),
    .o_status       (o_status)
);

FILE: sim/tb_lz4_block_decompressor.sv
// Testbench for lz4_block_decompressor: directed and random LZ4 streams in, result beats
// checked field by field against typed rows or a decoder here. Depends on lz4d_pkg and the RTL.
module tb_lz4_block_decompressor import lz4d_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       accepted;
        logic       copy_pending;
        logic       block_done;
        logic [1:0] status;
    } t_result;

    typedef enum logic {ROW_BEAT, ROW_SIZE} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [LEN_W-1:0] size;
        t_opcode          op;
        logic [7:0]       in_byte;
        logic             typed;
        t_result          want;
    } t_dir_row;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [CFG_AW-1:0] paddr     = '0;
    logic [CFG_DW-1:0] pwdata    = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;
    logic              i_valid   = 1'b0;
    logic              o_stall;
    logic [1:0]        i_opcode  = '0;
    logic [7:0]        i_in_byte = '0;
    logic              o_valid;
    logic              i_stall   = 1'b0;
    logic [7:0]        o_out_byte;
    logic              o_out_valid;
    logic              o_accepted;
    logic              o_copy_pending;
    logic              o_block_done;
    logic [1:0]        o_status;

    lz4_block_decompressor dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Decoder state mirrored from the block.
    logic [LEN_W-1:0] m_size    = OUT_SIZE_RESET;
    t_phase           m_phase   = PH_TOKEN;
    logic [3:0]       m_nib     = '0;
    logic [LEN_W-1:0] m_run     = '0;
    logic [15:0]      m_dist    = '0;
    logic [LEN_W-1:0] m_written = '0;
    logic [1:0]       m_status  = ST_OK;
    logic [7:0]       m_hist [HIST_DEPTH];

    t_result predicted_out[$];
    bit      calm = 1'b0;

    int n_bad = 0;
    int n_beats = 0;
    int n_directed = 0;
    int n_results = 0;
    int n_bytes = 0;
    int n_blocks = 0;
    int n_bad_offset = 0;
    int n_overrun = 0;
    int n_sizes = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    function automatic logic [LEN_W-1:0] add_sat(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
        logic [LEN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, RUN_MAX}) ? RUN_MAX : sum[LEN_W-1:0];
    endfunction

    function automatic void halt_with(logic [1:0] code);
        if (m_status == ST_OK)
            m_status = code;
        m_phase = PH_HALT;
    endfunction

    function automatic void end_of_literals();
        m_phase = (m_written >= m_size) ? PH_HALT : PH_OFFLO;
    endfunction

    function automatic logic store_byte(logic [7:0] v);
        if (m_written >= m_size) begin
            halt_with(ST_OVERRUN);
            return 1'b0;
        end
        m_hist[m_written[HIST_AW-1:0]] = v;
        m_written = m_written + 1'b1;
        return 1'b1;
    endfunction

    function automatic t_result decode_beat(t_opcode op, logic [7:0] b);
        t_result          r;
        logic [LEN_W-1:0] src;
        logic [7:0]       v;
        r = '0;
        r.accepted = 1'b1;
        case (op)
            OP_PUSH: begin
                case (m_phase)
                    PH_TOKEN: begin
                        m_nib = b[3:0];
                        m_run = LEN_W'(b[7:4]);
                        if (b[7:4] == NIB_MASK)
                            m_phase = PH_LITEXT;
                        else if (b[7:4] != 4'd0)
                            m_phase = PH_LIT;
                        else
                            end_of_literals();
                    end
                    PH_LITEXT: begin
                        m_run = add_sat(m_run, LEN_W'(b));
                        if (b != EXT_BYTE) begin
                            if (m_run != '0)
                                m_phase = PH_LIT;
                            else
                                end_of_literals();
                        end
                    end
                    PH_LIT: begin
                        if (store_byte(b)) begin
                            r.out_byte  = b;
                            r.out_valid = 1'b1;
                            m_run = m_run - 1'b1;
                            if (m_run == '0)
                                end_of_literals();
                        end
                    end
                    PH_OFFLO: begin
                        m_dist  = {8'h00, b};
                        m_phase = PH_OFFHI;
                    end
                    PH_OFFHI: begin
                        m_dist[15:8] = b;
                        if (m_dist == 16'd0 || LEN_W'(m_dist) > m_written) begin
                            halt_with(ST_BAD_OFFSET);
                        end else if (m_nib == NIB_MASK) begin
                            m_run   = LEN_W'(NIB_MASK);
                            m_phase = PH_MATEXT;
                        end else begin
                            m_run   = LEN_W'(m_nib) + MIN_MATCH;
                            m_phase = PH_COPY;
                        end
                    end
                    PH_MATEXT: begin
                        m_run = add_sat(m_run, LEN_W'(b));
                        if (b != EXT_BYTE) begin
                            m_run   = add_sat(m_run, MIN_MATCH);
                            m_phase = PH_COPY;
                        end
                    end
                    PH_COPY: r.accepted = 1'b0;
                    default: ;
                endcase
            end
            OP_PULL: begin
                if (m_phase == PH_COPY) begin
                    // The source trails the write pointer, so short offsets replicate.
                    src = m_written - LEN_W'(m_dist);
                    v = m_hist[src[HIST_AW-1:0]];
                    if (store_byte(v)) begin
                        r.out_byte  = v;
                        r.out_valid = 1'b1;
                        m_run = m_run - 1'b1;
                        if (m_run == '0)
                            m_phase = PH_TOKEN;
                    end
                end
            end
            OP_START: begin
                m_phase   = PH_TOKEN;
                m_nib     = '0;
                m_run     = '0;
                m_dist    = '0;
                m_written = '0;
                m_status  = ST_OK;
            end
            default: ;
        endcase
        r.copy_pending = (m_phase == PH_COPY);
        r.block_done   = (m_written >= m_size);
        r.status       = m_status;
        return r;
    endfunction

    // Picks the next beat from the decoder phase so that most sequences are well formed.
    function automatic void choose_beat(output t_opcode op, output logic [7:0] b);
        int unsigned roll, pick, reach, lo, hi_min, hi_max;
        roll  = $urandom_range(0, 99);
        pick  = $urandom_range(0, 19);
        b     = 8'($urandom);
        op    = OP_PUSH;
        reach = (m_written > 65535) ? 65535 : m_written;
        if (roll < 4) begin
            op = t_opcode'($urandom_range(0, 3));
            return;
        end
        case (m_phase)
            PH_TOKEN: begin
                if (pick < 3)
                    b[7:4] = 4'd0;
                else if (pick < 14)
                    b[7:4] = 4'($urandom_range(1, 4));
                else if (pick < 17)
                    b[7:4] = 4'($urandom_range(5, 14));
                else
                    b[7:4] = NIB_MASK;
            end
            PH_LITEXT, PH_MATEXT: begin
                if (pick < 2)
                    b = EXT_BYTE;
                else if (pick < 17)
                    b = 8'($urandom_range(0, 6));
                else
                    b = 8'($urandom_range(0, 254));
            end
            PH_OFFLO: begin
                if (reach != 0 && pick < 8)
                    b = 8'($urandom_range(1, (reach < 3) ? reach : 3));
                else if (reach != 0 && pick < 12)
                    b = 8'($urandom_range(1, (reach < 255) ? reach : 255));
            end
            PH_OFFHI: begin
                lo     = m_dist[7:0];
                hi_min = (lo == 0) ? 1 : 0;
                hi_max = (reach >= lo) ? (reach - lo) >> 8 : 0;
                if (roll >= 10 && reach >= lo && hi_max >= hi_min) begin
                    b = ($urandom_range(0, 2) != 0) ? 8'(hi_min)
                                                    : 8'($urandom_range(hi_min, hi_max));
                end else if (reach < lo) begin
                    b = 8'h00;
                end else begin
                    // Aim just past the bytes written so far.
                    b = (hi_max < 255) ? 8'(hi_max + 1) : 8'h00;
                end
            end
            PH_COPY: begin
                if (pick < 17)
                    op = OP_PULL;
                else if (pick == 19)
                    op = OP_NOP;
            end
            PH_HALT: begin
                if (pick < 14)
                    op = OP_START;
                else if (pick >= 18)
                    op = OP_PULL;
            end
            default: ;
        endcase
    endfunction

    function automatic t_dir_row drow(t_row_kind kind, logic [LEN_W-1:0] size, t_opcode op,
                                      logic [7:0] b, logic typed, t_result want);
        t_dir_row row;
        row.kind    = kind;
        row.size    = size;
        row.op      = op;
        row.in_byte = b;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    task automatic send_beat(t_opcode op, logic [7:0] b, logic typed, t_result want);
        t_result    pred;
        logic [1:0] was;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        was  = m_status;
        pred = decode_beat(op, b);
        predicted_out.push_back(typed ? want : pred);
        n_beats++;
        if (op == OP_START)
            n_blocks++;
        if (was == ST_OK && pred.status == ST_BAD_OFFSET)
            n_bad_offset++;
        if (was == ST_OK && pred.status == ST_OVERRUN)
            n_overrun++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (predicted_out.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_out_size(logic [LEN_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_OUTPUT_SIZE, 2'b00};
        pwdata  <= CFG_DW'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        m_size = v;
        n_sizes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== CFG_DW'(v)) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS)
                $display("ERROR: output_size read back %h, expected %h", prdata, CFG_DW'(v));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_side
        t_result seen;
        t_result want;
        if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end

        if (i_rst_n && o_valid && !i_stall) begin
            seen = {o_out_byte, o_out_valid, o_accepted, o_copy_pending, o_block_done, o_status};
            n_results++;
            if (seen.out_valid)
                n_bytes++;
            if (predicted_out.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("ERROR: result beat %0d arrived with nothing expected", n_results);
            end else begin
                want = predicted_out.pop_front();
                if (seen !== want) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS) begin
                        $display("ERROR: result beat %0d (expected/actual): byte %h/%h valid %b/%b",
                                 n_results, want.out_byte, seen.out_byte,
                                 want.out_valid, seen.out_valid);
                        $display("    accepted %b/%b pending %b/%b done %b/%b status %0d/%0d",
                                 want.accepted, seen.accepted,
                                 want.copy_pending, seen.copy_pending,
                                 want.block_done, seen.block_done, want.status, seen.status);
                    end
                end
            end
        end

        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_dir_row         rows[$];
        logic [LEN_W-1:0] sizes [N_PHASES];
        t_opcode          op;
        logic [7:0]       b;
        int               worked;

        // Typed results are {out_byte, out_valid, accepted, copy_pending, block_done, status}.
        rows.push_back(drow(ROW_BEAT, '0, OP_NOP, 8'h00, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK}));
        rows.push_back(drow(ROW_BEAT, '0, OP_PULL, 8'hFF, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK}));
        // One literal, then a six byte match at offset one that replicates it.
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h12, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'hFF, 1'b1,
                            {8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK}));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h01, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h00, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'hAA, 1'b1,
                            {8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK}));
        repeat (6)
            rows.push_back(drow(ROW_BEAT, '0, OP_PULL, 8'h00, 1'b0, '0));
        // Empty literal run followed by a zero offset.
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h00, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h00, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h00, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ST_BAD_OFFSET}));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h55, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ST_BAD_OFFSET}));
        rows.push_back(drow(ROW_BEAT, '0, OP_START, 8'h00, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK}));
        // Offset of two with only one byte written.
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h10, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h80, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h02, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h00, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ST_BAD_OFFSET}));
        rows.push_back(drow(ROW_BEAT, '0, OP_START, 8'h00, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b0, ST_OK}));
        // With a zero output size the block is done at once and any literal overruns.
        rows.push_back(drow(ROW_SIZE, '0, OP_NOP, 8'h00, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h00, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b1, ST_OK}));
        rows.push_back(drow(ROW_BEAT, '0, OP_START, 8'h00, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b1, ST_OK}));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h10, 1'b0, '0));
        rows.push_back(drow(ROW_BEAT, '0, OP_PUSH, 8'h7F, 1'b1,
                            {8'h00, 1'b0, 1'b1, 1'b0, 1'b1, ST_OVERRUN}));

        sizes[0] = 31'd24;
        sizes[1] = 31'd1;
        sizes[2] = 31'd1073741824;
        sizes[3] = LEN_W'($urandom_range(100, 3000));
        sizes[4] = OUT_SIZE_RESET;
        sizes[5] = 31'd500;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_SIZE) begin
                settle();
                write_out_size(rows[i].size);
            end else begin
                send_beat(rows[i].op, rows[i].in_byte, rows[i].typed, rows[i].want);
            end
        end
        n_directed = n_beats;

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            calm = (p == N_PHASES - 1);
            write_out_size(sizes[p]);
            send_beat(OP_START, 8'h00, 1'b0, '0);
            worked = 0;
            while (worked < ITEMS_PER_PHASE) begin
                choose_beat(op, b);
                // Beats the decoder drops or ignores do not count toward the phase.
                if (!(op == OP_NOP || (op == OP_PULL && m_phase != PH_COPY) ||
                      (op == OP_PUSH && (m_phase == PH_COPY || m_phase == PH_HALT))))
                    worked++;
                send_beat(op, b, 1'b0, '0);
            end
        end
        settle();

        $display("Run covered %0d input beats (%0d directed) and %0d result beats, %0d bytes out.",
                 n_beats, n_directed, n_results, n_bytes);
        $display("It started %0d blocks, hit %0d bad offsets and %0d overruns, %0d size writes.",
                 n_blocks, n_bad_offset, n_overrun, n_sizes);
        if (n_bad == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
